// ===== rtl/sha_pkg.sv =====
// ---------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ---------------------------------------------------------------------------
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       no_byte;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // One message-schedule word passed from the front to the back
    typedef struct packed {
        logic [31:0] word;
        logic        final_word;
    } sha_token_t;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [3:0] LEN_WORD_IDX = 4'd14;
    localparam logic [3:0] LAST_LOAD    = 4'd15;
    localparam logic [5:0] LAST_ROUND   = 6'd63;
    localparam logic [2:0] LAST_OUT     = 3'd7;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ===== rtl/sha256_stream_hasher_unit.sv =====
// ---------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 over a byte stream, digest emitted as eight 32-bit words.
// ---------------------------------------------------------------------------
// Input channel s_*: one transfer carries a byte (unless no_byte) and may
// end the message. Output channel m_*: eight transfers per message, word 0
// first, last_word set on word 7.
// Bytes are taken one per cycle while the word queue has room. Once a block's
// last word is loaded, the back end runs 64 rounds and then a chain update;
// meanwhile the front takes at most the 16 bytes that fit in the default
// four-word queue and then holds s_ready low. A steady stream's throughput
// is therefore set by the single round unit.
// At message end the front writes 3 to 18 padding words, one per cycle while
// the queue has room, and takes no input meanwhile; one or two final blocks
// follow, then the digest is offered one word per cycle while m_ready is high.
// While the receiver stalls the digest, the front keeps filling the queue
// until it is full. Reset (aresetn low, synchronous) loads the initial hash
// values and empties the queue; no clearing pass is needed.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_unit
    import sha_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sha_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sha_out_t m_data
);
    sha_token_t fq_in, fq_out;
    logic       fq_in_valid, fq_in_ready, fq_out_valid, fq_out_ready;

    sha_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .tok_valid (fq_in_valid),
        .tok_ready (fq_in_ready),
        .tok_data  (fq_in)
    );

    sha_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_in_valid),
        .in_ready  (fq_in_ready),
        .in_token  (fq_in),
        .out_valid (fq_out_valid),
        .out_ready (fq_out_ready),
        .out_token (fq_out)
    );

    sha_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (fq_out_valid),
        .tok_ready (fq_out_ready),
        .tok_data  (fq_out),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );
endmodule

// ===== rtl/sha_fifo.sv =====
// ---------------------------------------------------------------------------
// sha_fifo
// Short register queue of schedule words between the front and the back.
// ---------------------------------------------------------------------------
module sha_fifo
    import sha_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  sha_token_t in_token,
    output logic       out_valid,
    input  logic       out_ready,
    output sha_token_t out_token
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sha_token_t    mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_token = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_token;
        end
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/sha_front.sv =====
// ---------------------------------------------------------------------------
// sha_front
// Packs message bytes into big-endian words and appends the padding words.
// ---------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  sha_in_t    s_data,
    output logic       tok_valid,
    input  logic       tok_ready,
    output sha_token_t tok_data
);
    typedef enum logic [4:0] {
        F_ACCEPT    = 5'b00001,
        F_PAD_FIRST = 5'b00010,
        F_PAD_ZERO  = 5'b00100,
        F_LEN_HI    = 5'b01000,
        F_LEN_LO    = 5'b10000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [5:0]   pos_reg, pos_next;
    logic [31:0]  asm_reg, asm_next;
    logic [60:0]  total_reg, total_next;
    logic [3:0]   idx_reg, idx_next;
    logic [31:0]  pad_word;

    // first padding word: pending bytes, then the marker byte, then zeros
    always_comb begin
        case (pos_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {asm_reg[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {asm_reg[15:0], PAD_BYTE, 8'h0};
            default: pad_word = {asm_reg[23:0], PAD_BYTE};
        endcase
    end

    // accept bytes, then walk the padding words
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        asm_next   = asm_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        s_ready    = 1'b0;
        tok_valid  = 1'b0;
        tok_data   = '{word: 32'h0, final_word: 1'b0};
        case (state_reg)
            F_ACCEPT: begin
                s_ready = tok_ready;
                if (s_valid && tok_ready) begin
                    if (!s_data.no_byte) begin
                        asm_next   = {asm_reg[23:0], s_data.data_byte};
                        pos_next   = pos_reg + 1'b1;
                        total_next = total_reg + 1'b1;
                        if (pos_reg[1:0] == 2'd3) begin
                            tok_valid     = 1'b1;
                            tok_data.word = asm_next;
                        end
                    end
                    if (s_data.end_of_message) begin
                        state_next = F_PAD_FIRST;
                    end
                end
            end
            F_PAD_FIRST: begin
                tok_valid     = 1'b1;
                tok_data.word = pad_word;
                if (tok_ready) begin
                    idx_next   = pos_reg[5:2] + 1'b1;
                    state_next = (idx_next == LEN_WORD_IDX) ? F_LEN_HI : F_PAD_ZERO;
                end
            end
            F_PAD_ZERO: begin
                tok_valid = 1'b1;
                if (tok_ready) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_next == LEN_WORD_IDX) begin
                        state_next = F_LEN_HI;
                    end
                end
            end
            F_LEN_HI: begin
                tok_valid     = 1'b1;
                tok_data.word = total_reg[60:29];
                if (tok_ready) begin
                    state_next = F_LEN_LO;
                end
            end
            F_LEN_LO: begin
                tok_valid           = 1'b1;
                tok_data.word       = {total_reg[28:0], 3'b000};
                tok_data.final_word = 1'b1;
                if (tok_ready) begin
                    pos_next   = '0;
                    total_next = '0;
                    state_next = F_ACCEPT;
                end
            end
            default: begin
                state_next = F_ACCEPT;
            end
        endcase
    end

    // hold counters and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_ACCEPT;
            pos_reg   <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        asm_reg <= asm_next;
    end
endmodule

// ===== rtl/sha_back.sv =====
// ---------------------------------------------------------------------------
// sha_back
// Loads 16 schedule words, runs 64 rounds, updates the chain, emits digests.
// ---------------------------------------------------------------------------
module sha_back
    import sha_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       tok_valid,
    output logic       tok_ready,
    input  sha_token_t tok_data,
    output logic       m_valid,
    input  logic       m_ready,
    output sha_out_t   m_data
);
    typedef enum logic [3:0] {
        B_LOAD  = 4'b0001,
        B_ROUND = 4'b0010,
        B_ADD   = 4'b0100,
        B_OUT   = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        final_reg, final_next;
    logic [31:0] t1, t2, w_new;

    // one round and one schedule extension
    always_comb begin
        t1 = v_reg[7] + big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[cnt_reg] + w_reg[0];
        t2 = big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    end

    assign tok_ready = (state_reg == B_LOAD);
    assign m_valid   = (state_reg == B_OUT);
    assign m_data    = '{digest_word: chain_reg[oidx_reg], word_index: oidx_reg,
                         last_word: (oidx_reg == LAST_OUT)};

    always_comb begin
        state_next = state_reg;
        chain_next = chain_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        cnt_next   = cnt_reg;
        oidx_next  = oidx_reg;
        final_next = final_reg;
        case (state_reg)
            B_LOAD: begin
                if (tok_valid) begin
                    for (int i = 0; i < 15; i++) begin
                        w_next[i] = w_reg[i+1];
                    end
                    w_next[15] = tok_data.word;
                    final_next = tok_data.final_word;
                    cnt_next   = cnt_reg + 1'b1;
                    if (cnt_reg[3:0] == LAST_LOAD) begin
                        v_next     = chain_reg;
                        cnt_next   = '0;
                        state_next = B_ROUND;
                    end
                end
            end
            B_ROUND: begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i+1];
                end
                w_next[15] = w_new;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROUND) begin
                    cnt_next   = '0;
                    state_next = B_ADD;
                end
            end
            B_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                oidx_next  = '0;
                state_next = final_reg ? B_OUT : B_LOAD;
            end
            B_OUT: begin
                if (m_ready) begin
                    oidx_next = oidx_reg + 1'b1;
                    if (oidx_reg == LAST_OUT) begin
                        chain_next = INIT_HASH;
                        final_next = 1'b0;
                        state_next = B_LOAD;
                    end
                end
            end
            default: begin
                state_next = B_LOAD;
            end
        endcase
    end

    // hold control state and chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_LOAD;
            chain_reg <= INIT_HASH;
            cnt_reg   <= '0;
            oidx_reg  <= '0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            chain_reg <= chain_next;
            cnt_reg   <= cnt_next;
            oidx_reg  <= oidx_next;
            final_reg <= final_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg <= v_next;
        w_reg <= w_next;
    end
endmodule

// ===== tb/sha256_stream_hasher_unit_test.sv =====
// ---------------------------------------------------------------------------
// sha256_stream_hasher_unit_test
// Drives byte-stream messages into the SHA-256 hasher and checks every
// digest word against a SystemVerilog SHA-256 predictor, under random idling
// on both channels.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_unit_test;
    import sha_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int MAX_SHOWN = 10;
    localparam int RANDOM_ITEMS = 110;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sha_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    sha_out_t m_data;

    sha256_stream_hasher_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Hash state of the predictor
    logic [31:0] hash_words [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [60:0] msg_bytes;

    sha_out_t    digest_queue [$];
    int          mismatch_count;
    int          idle_cycles;
    bit          stim_done;

    // Directed stimulus: {data_byte, no_byte, end_of_message}
    sha_in_t directed_rows [10] = '{
        '{8'h00, 1'b1, 1'b1},   // empty message
        '{8'h61, 1'b0, 1'b0},   // "abc"
        '{8'h62, 1'b0, 1'b0},
        '{8'h63, 1'b0, 1'b1},   // byte and end together
        '{8'hff, 1'b1, 1'b0},   // empty item, ignored
        '{8'hff, 1'b0, 1'b0},
        '{8'h00, 1'b0, 1'b0},
        '{8'h00, 1'b1, 1'b0},
        '{8'h55, 1'b1, 1'b1},   // end with no byte after bytes
        '{8'haa, 1'b0, 1'b1}    // one-byte message
    };

    function automatic logic [31:0] rotr(logic [31:0] x, int r);
        return (x >> r) | (x << (32 - r));
    endfunction

    function automatic void reset_hash();
        for (int i = 0; i < 8; i++) hash_words[i] = INIT_HASH[i];
        block_fill = 0;
        msg_bytes = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hash_words[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_words[i] += v[i];
    endfunction

    // Advance the predictor by one accepted transfer
    function automatic void hash_transfer(sha_in_t item);
        logic [63:0] bit_len;
        int unsigned pos;
        sha_out_t word;
        if (!item.no_byte) begin
            msg_block[block_fill] = item.data_byte;
            block_fill++;
            msg_bytes++;
            if (block_fill == 64) begin
                compress_block();
                block_fill = 0;
            end
        end
        if (!item.end_of_message) return;
        pos = block_fill;
        msg_block[pos++] = PAD_BYTE;
        if (pos > 56) begin
            while (pos < 64) msg_block[pos++] = 8'h00;
            compress_block();
            pos = 0;
        end
        while (pos < 56) msg_block[pos++] = 8'h00;
        bit_len = {msg_bytes, 3'b000};
        for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            word.digest_word = hash_words[i];
            word.word_index = 3'(i);
            word.last_word = (i == 7);
            digest_queue.push_back(word);
        end
        reset_hash();
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Send one transfer, holding valid until accepted
    task automatic send_item(sha_in_t item);
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        hash_transfer(item);
        @(negedge aclk);
    endtask

    task automatic send_message(int unsigned len, bit noisy);
        sha_in_t item;
        for (int unsigned i = 0; i < len; i++) begin
            item.data_byte = 8'($urandom);
            item.no_byte = 1'b0;
            item.end_of_message = 1'b0;
            if (noisy && $urandom_range(0, 7) == 0) item.no_byte = 1'b1;
            send_item(item);
            if ($urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
        item.data_byte = 8'($urandom);
        item.no_byte = 1'($urandom_range(0, 1));
        item.end_of_message = 1'b1;
        send_item(item);
    endtask

    // Stimulus
    initial begin
        int unsigned sent;
        int unsigned len;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        mismatch_count = 0;
        stim_done = 0;
        reset_hash();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) send_item(directed_rows[i]);
        // Block boundary cases: 55, 56, 63, 64 bytes, then an end transfer with or without a byte
        send_message(55, 0);
        send_message(56, 0);
        send_message(63, 0);
        send_message(64, 0);
        s_valid <= 1'b0;
        @(negedge aclk);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(60, 130);
                default: len = $urandom_range(0, 20);
            endcase
            send_message(len, $urandom_range(0, 3) == 0);
            sent += len + 1;
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        stim_done = 1;
    end

    // Receiver stall pattern
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            case ($urandom_range(0, 3))
                0: m_ready <= 1'b0;
                1: m_ready <= ($urandom_range(0, 2) != 0);
                default: m_ready <= 1'b1;
            endcase
        end
    end

    // Check digest words
    always @(posedge aclk) begin
        sha_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected digest word %h idx %0d", m_data.digest_word,
                             m_data.word_index);
            end else begin
                want = digest_queue.pop_front();
                if (m_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 want.digest_word, want.word_index, want.last_word,
                                 m_data.digest_word, m_data.word_index, m_data.last_word);
                end
            end
        end
    end

    // Watchdog and end of run
    initial begin
        idle_cycles = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
            if (stim_done && digest_queue.size() == 0) begin
                repeat (DRAIN_CYCLES) @(posedge aclk);
                if (mismatch_count == 0 && digest_queue.size() == 0) begin
                    $display("TB_OK");
                end else begin
                    $display("TB_ERROR");
                end
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/sha_pkg.sv
rtl/sha_fifo.sv
rtl/sha_front.sv
rtl/sha_back.sv
rtl/sha256_stream_hasher_unit.sv
tb/sha256_stream_hasher_unit_test.sv
